FILE: src/nmea_sentence_capture_defines.svh
// Assertion macros shared by the checker of nmea_sentence_capture.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef NMEA_SENTENCE_CAPTURE_DEFINES_SVH
`define NMEA_SENTENCE_CAPTURE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define NSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define NSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define NSC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nsc_pkg.sv
// Package for the NMEA sentence capture block: opcodes, register indexes,
// state encoding, store command struct and character constants. No dependencies.
`default_nettype none

package nsc_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 128;

  localparam logic [7:0] START_CHAR_RST = 8'd36;  // '$'
  localparam logic [7:0] END_CHAR_RST   = 8'd10;  // LF

  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_C = 8'h43;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } nsc_op_t;

  typedef enum logic {
    CFG_START_CHAR = 1'b0,
    CFG_END_CHAR   = 1'b1
  } nsc_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_COPY = 4'b0100,
    ST_RESP = 4'b1000
  } nsc_state_t;

  typedef struct packed {
    logic line_we;
    logic copy_start;
  } nsc_cmd_t;

endpackage

`default_nettype wire

FILE: src/nsc_store.sv
// Line store and capture store memories with the sentence copy engine.
// Depends on nsc_pkg.
`default_nettype none

module nsc_store #(
  parameter int unsigned LINE_DEPTH = nsc_pkg::LINE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(LINE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire nsc_pkg::nsc_cmd_t cmd,
  input  wire logic [AW-1:0]    line_waddr,
  input  wire logic [7:0]       line_wdata,
  input  wire logic [AW-1:0]    copy_len,
  input  wire logic [AW-1:0]    cap_raddr,
  output logic      [7:0]       cap_rbyte,
  output logic                  copy_busy
);
  import nsc_pkg::*;

  logic [7:0]            line_mem_r [LINE_DEPTH];
  logic [7:0]            cap_mem_r  [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] cap_vld_r;

  logic [7:0]    line_rdata_r;
  logic [7:0]    cap_rdata_r;
  logic          cap_rvld_r;
  logic          copy_act_r;
  logic [AW-1:0] copy_idx_r;
  logic [AW-1:0] copy_len_r;
  logic          cp_wv_r;
  logic [AW-1:0] cp_waddr_r;

  always_ff @(posedge clk) begin
    if (cmd.line_we) begin
      line_mem_r[line_waddr] <= line_wdata;
    end
    line_rdata_r <= line_mem_r[copy_idx_r];
  end

  // copy write lands in the cycle after its line store read
  always_ff @(posedge clk) begin
    if (cp_wv_r) begin
      cap_mem_r[cp_waddr_r] <= line_rdata_r;
    end
    cap_rdata_r <= cap_mem_r[cap_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_act_r <= 1'b0;
      copy_idx_r <= '0;
      copy_len_r <= '0;
      cp_wv_r    <= 1'b0;
      cp_waddr_r <= '0;
      cap_vld_r  <= '0;
      cap_rvld_r <= 1'b0;
    end else begin
      cap_rvld_r <= cap_vld_r[cap_raddr];
      cp_wv_r    <= copy_act_r;
      cp_waddr_r <= copy_idx_r;
      if (cp_wv_r) begin
        cap_vld_r[cp_waddr_r] <= 1'b1;
      end
      if (cmd.copy_start) begin
        copy_act_r <= 1'b1;
        copy_idx_r <= '0;
        copy_len_r <= copy_len;
      end else if (copy_act_r) begin
        copy_idx_r <= copy_idx_r + AW'(1);
        if (copy_idx_r == copy_len_r - AW'(1)) begin
          copy_act_r <= 1'b0;
        end
      end
    end
  end

  // never-written capture entries read as zero
  assign cap_rbyte = cap_rvld_r ? cap_rdata_r : 8'h00;
  assign copy_busy = copy_act_r | cp_wv_r;

endmodule

`default_nettype wire

FILE: src/nmea_sentence_capture.sv
// NMEA sentence capture: receives serial bytes into a line store and keeps one
// captured RMC sentence for readout. Depends on nsc_pkg and nsc_store.
//
// Input channel (in_valid/in_stall): one item per handshake. in_opcode selects
// a received byte (in_data_byte), a read of the capture store (in_read_index)
// or a release of the capture. Every item yields exactly one result item on the
// out_ channel: read byte, capture full flag, capture length, captured-now.
// Configuration (cfg_we/cfg_index/cfg_data) sets the start and end characters;
// write it only while no item is in flight.
// Flow: an item is registered on acceptance in IDLE, and its result is formed
// in EXEC and loaded into the output register. A byte that completes a
// captured sentence adds a copy sweep of the line store into the capture
// store in COPY: one entry per cycle through the line store read port.
// Only one item is in flight; in_stall is high from acceptance until its
// result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the output register, drops any
// sentence in progress and any capture; capture entries not yet written read 0.
// When out_stall holds a result, the next item is still taken and its result
// waits in a holding register until the output register frees up.
`default_nettype none

module nmea_sentence_capture #(
  parameter int unsigned LINE_DEPTH = nsc_pkg::LINE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_read_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_byte,
  output logic            out_capture_full,
  output logic [6:0]      out_capture_length,
  output logic            out_captured_now,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);
  import nsc_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  nsc_state_t state_r, state_nxt;

  logic [7:0]    start_char_r;
  logic [7:0]    end_char_r;
  logic          in_sent_r;
  logic [AW-1:0] pos_r;
  logic          held_r;
  logic [AW-1:0] cap_len_r;
  logic [7:0]    sh_r   [1:5];  // copy of line slots 1..5 for the RMC check
  logic [7:0]    sh_nxt [1:5];

  nsc_op_t       op_r;
  logic [7:0]    data_r;
  logic          rng_r;

  logic          out_valid_r;
  logic [7:0]    out_rb_r;
  logic          out_full_r;
  logic [6:0]    out_len_r;
  logic          out_now_r;
  logic [7:0]    res_rb_r;
  logic          res_full_r;
  logic [6:0]    res_len_r;
  logic          res_now_r;

  logic          accept;
  logic          is_start, in_frame, end_hit, rmc, exec_byte, do_cap;
  logic [AW-1:0] base_pos, adv_pos;
  logic [8:0]    idx_ext, len_ext;
  logic          produce, slot_free, load_out, park;
  logic [7:0]    res_rb;
  logic          res_full, res_now;
  logic [6:0]    res_len;
  logic [7:0]    cap_rbyte;
  logic          copy_busy;
  nsc_cmd_t      cmd;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign idx_ext   = 9'(in_read_index);
  assign len_ext   = 9'(cap_len_r);

  always_comb begin
    is_start = (data_r == start_char_r);
    in_frame = is_start | in_sent_r;
    base_pos = is_start ? '0 : pos_r;
    adv_pos  = (base_pos == AW'(LINE_DEPTH - 1)) ? '0 : base_pos + AW'(1);
    // end char ends only if the position did not wrap to zero
    end_hit  = in_frame && (data_r == end_char_r) && (adv_pos != '0);
    for (int k = 1; k <= 5; k++) begin
      sh_nxt[k] = sh_r[k];
      if (in_frame && base_pos == AW'(k)) begin
        sh_nxt[k] = data_r;
      end
      if (end_hit && adv_pos == AW'(k)) begin
        sh_nxt[k] = 8'h00;
      end
    end
    rmc = (sh_nxt[1] == CH_G) && (sh_nxt[2] == CH_P) && (sh_nxt[3] == CH_R) &&
          (sh_nxt[4] == CH_M) && (sh_nxt[5] == CH_C);
    exec_byte = (state_r == ST_EXEC) && (op_r == OP_BYTE);
    do_cap    = exec_byte && end_hit && rmc && !held_r;
  end

  // terminator only matters through the slot 1..5 copy, so the store takes
  // just the data byte
  always_comb begin
    cmd.line_we    = exec_byte && in_frame;
    cmd.copy_start = do_cap;
  end

  nsc_store #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .line_waddr (base_pos),
    .line_wdata (data_r),
    .copy_len   (adv_pos),
    .cap_raddr  (idx_ext[AW-1:0]),
    .cap_rbyte  (cap_rbyte),
    .copy_busy  (copy_busy)
  );

  always_comb begin
    state_nxt = state_r;
    produce   = 1'b0;
    res_rb    = 8'h00;
    res_full  = held_r;
    res_len   = len_ext[6:0];
    res_now   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (do_cap) begin
          state_nxt = ST_COPY;
        end else begin
          produce = 1'b1;
          if (op_r == OP_READ && rng_r) res_rb = cap_rbyte;
          if (op_r == OP_RELEASE) res_full = 1'b0;
        end
      end
      ST_COPY: begin
        if (!copy_busy) begin
          produce  = 1'b1;
          res_full = 1'b1;
          res_now  = 1'b1;
        end
      end
      ST_RESP: begin
        produce  = 1'b1;
        res_rb   = res_rb_r;
        res_full = res_full_r;
        res_len  = res_len_r;
        res_now  = res_now_r;
      end
      default: state_nxt = ST_IDLE;
    endcase
    load_out = produce && slot_free;
    park     = produce && !slot_free;
    if (load_out) state_nxt = ST_IDLE;
    else if (park) state_nxt = ST_RESP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_char_r <= START_CHAR_RST;
      end_char_r   <= END_CHAR_RST;
      in_sent_r    <= 1'b0;
      pos_r        <= '0;
      held_r       <= 1'b0;
      cap_len_r    <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 1; k <= 5; k++) begin
        sh_r[k] <= 8'h00;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (nsc_cfg_idx_t'(cfg_index))
          CFG_START_CHAR: start_char_r <= cfg_data;
          CFG_END_CHAR:   end_char_r   <= cfg_data;
          default:        start_char_r <= start_char_r;
        endcase
      end
      if (exec_byte) begin
        sh_r <= sh_nxt;
        if (in_frame) begin
          pos_r     <= adv_pos;
          in_sent_r <= !end_hit;
        end
      end
      if (do_cap) begin
        held_r    <= 1'b1;
        cap_len_r <= adv_pos;
      end
      if (state_r == ST_EXEC && op_r == OP_RELEASE) begin
        held_r <= 1'b0;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= nsc_op_t'(in_opcode);
      data_r <= in_data_byte;
      rng_r  <= ({2'b00, in_read_index} < 9'(LINE_DEPTH));
    end
    if (load_out) begin
      out_rb_r   <= res_rb;
      out_full_r <= res_full;
      out_len_r  <= res_len;
      out_now_r  <= res_now;
    end
    if (park) begin
      res_rb_r   <= res_rb;
      res_full_r <= res_full;
      res_len_r  <= res_len;
      res_now_r  <= res_now;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_byte      = out_rb_r;
  assign out_capture_full   = out_full_r;
  assign out_capture_length = out_len_r;
  assign out_captured_now   = out_now_r;

endmodule

`default_nettype wire

FILE: src/nsc_checker.sv
// Port-level checker for nmea_sentence_capture, bound to the top level.
// Depends on nmea_sentence_capture_defines.svh.
`default_nettype none

`include "nmea_sentence_capture_defines.svh"

module nsc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_opcode,
  input wire logic [7:0] in_data_byte,
  input wire logic [6:0] in_read_index,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_read_byte,
  input wire logic       out_capture_full,
  input wire logic [6:0] out_capture_length,
  input wire logic       out_captured_now,
  input wire logic       cfg_we,
  input wire logic       cfg_index,
  input wire logic [7:0] cfg_data
);

  // a held result keeps its payload
  `NSC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_byte) && $stable(out_capture_length) && $stable(out_captured_now), "stalled result changed")

  // a fresh capture is always reported as held
  `NSC_ASSERT_IMP(a_cap_full, out_valid && out_captured_now, out_capture_full, "captured item without full flag")

  // a captured sentence never has zero length
  `NSC_ASSERT_IMP(a_cap_len, out_valid && out_captured_now, out_capture_length != 7'd0, "captured item with zero length")

  // reset empties the output register
  `NSC_ASSERT_RST(a_rst_out, !rst_n, !out_valid, "result present after reset")

endmodule

bind nmea_sentence_capture nsc_checker u_nsc_checker (.*);

`default_nettype wire
